>>> rtl/stq_pkg.sv
// Shared types and constants for the sorted interval table query block.
`timescale 1ns / 1ps
package stq_pkg;

    // Fixed widths of the external fields
    localparam int SAMPLE_PORT_W = 48;
    localparam int CLASS_W       = 5;
    localparam int POS_W         = 6;
    localparam int MASK_W        = 32;
    localparam int MPQ_W         = 7;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 32;

    // Defaults for the top-level parameters
    localparam int DEF_TABLE_DEPTH  = 64;
    localparam int DEF_BLOCK_SIZE   = 16;
    localparam int DEF_CLASS_COUNT  = 32;
    localparam int DEF_SAMPLE_WIDTH = 48;

    // Input item kinds
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MASK = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MPQ  = 1'd1;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_MATCH    = 2'd2,
        ST_NOMATCH  = 2'd3
    } t_status;

    // One result transaction
    typedef struct packed {
        t_status                  status;
        logic [POS_W-1:0]         position;
        logic [SAMPLE_PORT_W-1:0] hit_start;
        logic [SAMPLE_PORT_W-1:0] hit_end;
        logic [CLASS_W-1:0]       hit_class;
        logic                     last;
    } t_res;

    // Control of the cell row
    typedef struct packed {
        logic rot;   // every cell takes its upper neighbor, the top cell takes cell 0
        logic ins;   // open a gap at the insert position and write the new entry
    } t_cell_ctl;

endpackage

>>> rtl/stq_in_if.sv
// Input channel: valid/ready handshake with one insert or query item.
`timescale 1ns / 1ps
interface stq_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 kind;
    logic [stq_pkg::SAMPLE_PORT_W-1:0]    first_sample;
    logic [stq_pkg::SAMPLE_PORT_W-1:0]    final_sample;
    logic [stq_pkg::CLASS_W-1:0]          class_id;

    modport source (output valid, kind, first_sample, final_sample, class_id, input ready);
    modport sink   (input valid, kind, first_sample, final_sample, class_id, output ready);
endinterface

>>> rtl/stq_out_if.sv
// Output channel: valid/ready handshake with one result item.
`timescale 1ns / 1ps
interface stq_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           status;
    logic [stq_pkg::POS_W-1:0]            position;
    logic [stq_pkg::SAMPLE_PORT_W-1:0]    hit_start;
    logic [stq_pkg::SAMPLE_PORT_W-1:0]    hit_end;
    logic [stq_pkg::CLASS_W-1:0]          hit_class;
    logic                                 last;

    modport source (output valid, status, position, hit_start, hit_end, hit_class, last,
                    input ready);
    modport sink   (input valid, status, position, hit_start, hit_end, hit_class, last,
                    output ready);
endinterface

>>> rtl/stq_cell.sv
// One table cell: holds one interval and moves it along the row.
`timescale 1ns / 1ps
module stq_cell #(
    parameter int SAMPLE_WIDTH = stq_pkg::DEF_SAMPLE_WIDTH,
    parameter int IDX_W        = 6,
    parameter int IDX          = 0
) (
    input  logic                        i_clk,
    input  stq_pkg::t_cell_ctl          i_ctl,
    input  logic [IDX_W-1:0]            i_pos,
    input  logic [SAMPLE_WIDTH-1:0]     i_new_start,
    input  logic [SAMPLE_WIDTH-1:0]     i_new_end,
    input  logic [stq_pkg::CLASS_W-1:0] i_new_class,
    input  logic [SAMPLE_WIDTH-1:0]     i_nxt_start,
    input  logic [SAMPLE_WIDTH-1:0]     i_nxt_end,
    input  logic [stq_pkg::CLASS_W-1:0] i_nxt_class,
    input  logic [SAMPLE_WIDTH-1:0]     i_prv_start,
    input  logic [SAMPLE_WIDTH-1:0]     i_prv_end,
    input  logic [stq_pkg::CLASS_W-1:0] i_prv_class,
    output logic [SAMPLE_WIDTH-1:0]     o_start,
    output logic [SAMPLE_WIDTH-1:0]     o_end,
    output logic [stq_pkg::CLASS_W-1:0] o_class
);

    logic [SAMPLE_WIDTH-1:0]     r_start;
    logic [SAMPLE_WIDTH-1:0]     r_end;
    logic [stq_pkg::CLASS_W-1:0] r_class;

    // rotate toward cell 0, or take the new entry / lower neighbor on insert
    always_ff @(posedge i_clk) begin
        if (i_ctl.rot) begin
            r_start <= i_nxt_start;
            r_end   <= i_nxt_end;
            r_class <= i_nxt_class;
        end else if (i_ctl.ins && i_pos == IDX_W'(IDX)) begin
            r_start <= i_new_start;
            r_end   <= i_new_end;
            r_class <= i_new_class;
        end else if (i_ctl.ins && i_pos < IDX_W'(IDX)) begin
            r_start <= i_prv_start;
            r_end   <= i_prv_end;
            r_class <= i_prv_class;
        end
    end

    assign o_start = r_start;
    assign o_end   = r_end;
    assign o_class = r_class;

endmodule

>>> rtl/sorted_interval_table_query.sv
// Sorted interval table: a row of TABLE_DEPTH cells keeps intervals ordered by start sample.
// An insert whose start is not below the last appended start is appended at once; any other
// insert first rotates the whole row once to find its place and then shifts the upper entries
// up by one cell together. A query rotates the row twice, once to find the first block with an
// end past the range start and the stopping entry, once to emit hits, with a stride search by
// repeated addition between the passes when thinning. A query on an empty table or with every
// class masked skips both passes. The emit pass holds while the output is stalled.
// Results leave through an output register; a new item is taken once the previous one is done.
`timescale 1ns / 1ps
module sorted_interval_table_query #(
    parameter int TABLE_DEPTH  = stq_pkg::DEF_TABLE_DEPTH,
    parameter int BLOCK_SIZE   = stq_pkg::DEF_BLOCK_SIZE,
    parameter int CLASS_COUNT  = stq_pkg::DEF_CLASS_COUNT,
    parameter int SAMPLE_WIDTH = stq_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [stq_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [stq_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    stq_in_if.sink                            i_in,
    stq_out_if.source                         o_out
);

    localparam int IW  = $clog2(TABLE_DEPTH);
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int BW  = $clog2(BLOCK_SIZE + 1);
    localparam int AW  = stq_pkg::MPQ_W + 1;
    localparam logic [stq_pkg::MASK_W-1:0] CMASK = (CLASS_COUNT >= 32) ? '1 :
        stq_pkg::MASK_W'((64'd1 << CLASS_COUNT) - 64'd1);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_INS, S_QEND, S_STRIDE, S_EMIT, S_FIN
    } t_state;

    t_state                       r_state;
    logic [CW-1:0]                r_count;
    logic [SAMPLE_WIDTH-1:0]      r_last_app;
    logic [stq_pkg::MASK_W-1:0]   r_mask;
    logic [stq_pkg::MPQ_W-1:0]    r_mpq;
    logic                         r_kind;
    logic [SAMPLE_WIDTH-1:0]      r_s;
    logic [SAMPLE_WIDTH-1:0]      r_e;
    logic [stq_pkg::CLASS_W-1:0]  r_c;
    logic [IW-1:0]                r_t;
    logic [IW-1:0]                r_pos;
    logic                         r_ff;
    logic                         r_cv;
    logic [CW-1:0]                r_cand;
    logic                         r_lxv;
    logic [CW-1:0]                r_first;
    logic [CW-1:0]                r_lastx;
    logic [BW-1:0]                r_blkcnt;
    logic [CW-1:0]                r_blkbase;
    logic [AW-1:0]                r_acc;
    logic [stq_pkg::MPQ_W-1:0]    r_k;
    logic [stq_pkg::MPQ_W-1:0]    r_stride;
    logic [stq_pkg::MPQ_W-1:0]    r_phase;
    logic                         r_pend_v;
    stq_pkg::t_res                r_pend;
    logic                         r_ov;
    stq_pkg::t_res                r_out;

    stq_pkg::t_cell_ctl           cell_ctl;
    logic [SAMPLE_WIDTH-1:0]      c_start [TABLE_DEPTH];
    logic [SAMPLE_WIDTH-1:0]      c_end   [TABLE_DEPTH];
    logic [stq_pkg::CLASS_W-1:0]  c_class [TABLE_DEPTH];

    logic [SAMPLE_WIDTH-1:0]      in_s;
    logic [SAMPLE_WIDTH-1:0]      in_e;
    logic [stq_pkg::MASK_W-1:0]   vis;
    logic                         all_vis;
    logic                         in_fire;
    logic                         out_free;
    logic                         out_load;
    logic                         t_end;
    logic                         in_rng;
    logic                         n_cv;
    logic [CW-1:0]                n_cand;
    logic [CW-1:0]                cnt;
    logic                         thin;
    logic                         in_win;
    logic                         vis_ok;
    logic                         hit;
    logic                         advance;
    stq_pkg::t_res                head_res;
    stq_pkg::t_res                fin_res;

    assign in_s     = SAMPLE_WIDTH'(i_in.first_sample);
    assign in_e     = SAMPLE_WIDTH'(i_in.final_sample);
    assign vis      = r_mask & CMASK;
    assign all_vis  = (vis == CMASK);
    assign in_fire  = i_in.valid && i_in.ready;
    assign out_free = !r_ov || o_out.ready;
    assign t_end    = (r_t == IW'(TABLE_DEPTH - 1));
    assign in_rng   = (CW'(r_t) < r_count);

    // first-pass tracking of the stop candidate inside the current block
    always_comb begin
        n_cv   = (r_blkcnt == '0) ? 1'b0 : r_cv;
        n_cand = r_cand;
        if (!n_cv && c_start[0] > r_e) begin
            n_cv   = 1'b1;
            n_cand = CW'(r_t);
        end
    end

    // thinning stride and emit-pass hit detection
    assign cnt    = r_lastx - r_first;
    assign thin   = all_vis && (r_mpq != '0) && (AW'(cnt) > AW'(r_mpq));
    assign in_win = (CW'(r_t) >= r_first) && (CW'(r_t) < r_lastx);
    assign vis_ok = (6'(c_class[0]) < 6'(CLASS_COUNT)) && r_mask[c_class[0]];
    assign hit    = in_win && (r_phase == '0) && (c_end[0] > r_s) && (all_vis || vis_ok);
    assign advance = !(hit && r_pend_v && !out_free);

    // output register loads on a pushed-out hit or on the final result
    assign out_load = (r_state == S_EMIT && advance && hit && r_pend_v)
                   || (r_state == S_FIN && out_free);

    always_comb begin
        head_res.status    = stq_pkg::ST_MATCH;
        head_res.position  = stq_pkg::POS_W'(r_t);
        head_res.hit_start = stq_pkg::SAMPLE_PORT_W'(c_start[0]);
        head_res.hit_end   = stq_pkg::SAMPLE_PORT_W'(c_end[0]);
        head_res.hit_class = c_class[0];
        head_res.last      = 1'b0;
    end

    // held result marked as the final one
    always_comb begin
        fin_res      = r_pend;
        fin_res.last = 1'b1;
    end

    // cell row control
    always_comb begin
        cell_ctl.rot = (r_state == S_SCAN) || (r_state == S_EMIT && advance);
        cell_ctl.ins = (r_state == S_INS);
    end

    // the cell row
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        localparam int NXT = (g + 1) % TABLE_DEPTH;
        localparam int PRV = (g == 0) ? 0 : g - 1;
        stq_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .IDX_W        (IW),
            .IDX          (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (cell_ctl),
            .i_pos       (r_pos),
            .i_new_start (r_s),
            .i_new_end   (r_e),
            .i_new_class (r_c),
            .i_nxt_start (c_start[NXT]),
            .i_nxt_end   (c_end[NXT]),
            .i_nxt_class (c_class[NXT]),
            .i_prv_start (c_start[PRV]),
            .i_prv_end   (c_end[PRV]),
            .i_prv_class (c_class[PRV]),
            .o_start     (c_start[g]),
            .o_end       (c_end[g]),
            .o_class     (c_class[g])
        );
    end

    // sequencer, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_last_app <= '0;
            r_mask     <= '1;
            r_mpq      <= '0;
            r_pend_v   <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    stq_pkg::CFG_MASK: r_mask <= i_cfg_data;
                    stq_pkg::CFG_MPQ:  r_mpq  <= i_cfg_data[stq_pkg::MPQ_W-1:0];
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_kind    <= i_in.kind;
                        r_s       <= in_s;
                        r_e       <= in_e;
                        r_c       <= i_in.class_id;
                        r_t       <= '0;
                        r_blkcnt  <= '0;
                        r_blkbase <= '0;
                        r_ff      <= 1'b0;
                        r_cv      <= 1'b0;
                        r_lxv     <= 1'b0;
                        if (i_in.kind == stq_pkg::KIND_INSERT) begin
                            if (r_count == CW'(TABLE_DEPTH)) begin
                                r_pend   <= '{status: stq_pkg::ST_FULL, last: 1'b1,
                                              default: '0};
                                r_pend_v <= 1'b1;
                                r_state  <= S_FIN;
                            end else if (in_s >= r_last_app) begin
                                r_pos      <= IW'(r_count);
                                r_last_app <= in_s;
                                r_state    <= S_INS;
                            end else begin
                                r_pos   <= '0;
                                r_state <= S_SCAN;
                            end
                        end else if (vis == '0 || r_count == '0) begin
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end

                S_SCAN: begin
                    r_t <= r_t + IW'(1);
                    if (r_kind == stq_pkg::KIND_INSERT) begin
                        // place after the last entry whose start is not greater
                        if (in_rng && c_start[0] <= r_s) begin
                            r_pos <= r_t + IW'(1);
                        end
                    end else begin
                        if (in_rng && !r_ff) begin
                            r_cv   <= n_cv;
                            r_cand <= n_cand;
                            if (c_end[0] > r_s) begin
                                r_ff    <= 1'b1;
                                r_first <= r_blkbase;
                                r_lxv   <= n_cv;
                                r_lastx <= n_cand;
                            end
                        end
                        if (in_rng && r_ff && !r_lxv && c_start[0] > r_e) begin
                            r_lxv   <= 1'b1;
                            r_lastx <= CW'(r_t);
                        end
                        // block boundary tracking
                        if (r_blkcnt == BW'(BLOCK_SIZE - 1)) begin
                            r_blkcnt  <= '0;
                            r_blkbase <= CW'(r_t) + CW'(1);
                        end else begin
                            r_blkcnt <= r_blkcnt + BW'(1);
                        end
                    end
                    if (t_end) begin
                        r_state <= (r_kind == stq_pkg::KIND_INSERT) ? S_INS : S_QEND;
                    end
                end

                S_INS: begin
                    r_count  <= r_count + CW'(1);
                    r_pend   <= '{status: stq_pkg::ST_INSERTED,
                                  position: stq_pkg::POS_W'(r_pos),
                                  hit_start: stq_pkg::SAMPLE_PORT_W'(r_s),
                                  hit_end: stq_pkg::SAMPLE_PORT_W'(r_e),
                                  hit_class: r_c, last: 1'b1};
                    r_pend_v <= 1'b1;
                    r_state  <= S_FIN;
                end

                S_QEND: begin
                    // no block past the range start, or no stopping entry
                    if (!r_ff) begin
                        r_first <= r_count;
                        r_lastx <= r_count;
                    end else if (!r_lxv) begin
                        r_lastx <= r_count;
                    end
                    r_acc   <= AW'(r_mpq);
                    r_k     <= stq_pkg::MPQ_W'(1);
                    r_state <= S_STRIDE;
                end

                S_STRIDE: begin
                    // ceil(cnt / limit) by repeated addition
                    if (!thin || r_acc >= AW'(cnt)) begin
                        r_stride <= thin ? r_k : stq_pkg::MPQ_W'(1);
                        r_phase  <= '0;
                        r_t      <= '0;
                        r_state  <= S_EMIT;
                    end else begin
                        r_acc <= r_acc + AW'(r_mpq);
                        r_k   <= r_k + stq_pkg::MPQ_W'(1);
                    end
                end

                S_EMIT: begin
                    if (advance) begin
                        r_t <= r_t + IW'(1);
                        if (in_win) begin
                            r_phase <= (r_phase == '0) ? r_stride - stq_pkg::MPQ_W'(1)
                                                       : r_phase - stq_pkg::MPQ_W'(1);
                        end
                        // hold one hit back so the final one can carry last
                        if (hit) begin
                            if (r_pend_v) begin
                                r_out <= r_pend;
                            end
                            r_pend   <= head_res;
                            r_pend_v <= 1'b1;
                        end
                        if (t_end) begin
                            r_state <= S_FIN;
                        end
                    end
                end

                S_FIN: begin
                    if (out_free) begin
                        if (r_pend_v) begin
                            r_out <= fin_res;
                        end else begin
                            r_out <= '{status: stq_pkg::ST_NOMATCH, last: 1'b1, default: '0};
                        end
                        r_pend_v <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase

            // output valid: set on load, cleared once taken
            r_ov <= out_load || (r_ov && !o_out.ready);
        end
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_ov;
    assign o_out.status    = r_out.status;
    assign o_out.position  = r_out.position;
    assign o_out.hit_start = r_out.hit_start;
    assign o_out.hit_end   = r_out.hit_end;
    assign o_out.hit_class = r_out.hit_class;
    assign o_out.last      = r_out.last;

endmodule

>>> rtl/stq_checker.sv
// Port-level checks for the sorted interval table query block, bound to the top level.
`timescale 1ns / 1ps
module stq_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              i_in_ready,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic [1:0]                        i_out_status,
    input logic [stq_pkg::POS_W-1:0]         i_out_position,
    input logic [stq_pkg::SAMPLE_PORT_W-1:0] i_out_hit_start,
    input logic [stq_pkg::SAMPLE_PORT_W-1:0] i_out_hit_end,
    input logic [stq_pkg::CLASS_W-1:0]       i_out_hit_class,
    input logic                              i_out_last
);

    // a stalled result stays valid with its status, position, hit start and last held
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_status)
            && $stable(i_out_position) && $stable(i_out_hit_start) && $stable(i_out_last))
        else $error("stalled result changed");

    // an insert result, inserted or full, carries last
    a_ins_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status == stq_pkg::ST_INSERTED
            || i_out_status == stq_pkg::ST_FULL) |-> i_out_last)
        else $error("insert result without last");

    // no-match and full results carry zero payload
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status == stq_pkg::ST_NOMATCH
            || i_out_status == stq_pkg::ST_FULL) |-> i_out_position == '0
            && i_out_hit_start == '0 && i_out_hit_end == '0 && i_out_hit_class == '0)
        else $error("empty result with payload");

    // one item at a time: accepting an item drops ready
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second item accepted while busy");

endmodule

bind sorted_interval_table_query stq_checker u_stq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_status    (o_out.status),
    .i_out_position  (o_out.position),
    .i_out_hit_start (o_out.hit_start),
    .i_out_hit_end   (o_out.hit_end),
    .i_out_hit_class (o_out.hit_class),
    .i_out_last      (o_out.last)
);
